### rtl/triangle_list_assembly_assert.svh
// assertion macros shared by the triangle list assembly rtl
`ifndef TRIANGLE_LIST_ASSEMBLY_ASSERT_SVH
`define TRIANGLE_LIST_ASSEMBLY_ASSERT_SVH

// checked only while out of reset
`define TLA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define TLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tla_pkg.sv
// shared types and constants of the triangle list assembly block
`timescale 1ns / 1ps

package tla_pkg;

  localparam int unsigned INDEX_WIDTH_DEF = 32;
  localparam int unsigned OUT_INDEX_W     = 32;
  localparam int unsigned MODE_W          = 3;
  localparam int unsigned TRI_SIDES       = 3;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [MODE_W-1:0] MODE_TRIANGLES = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STRIP     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FAN       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RESET     = MODE_TRIANGLES;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ODD_COUNT = 2'd1,
    STATUS_BAD_MODE  = 2'd2
  } status_e;

  // control part of one queued job: up to three results
  typedef struct packed {
    logic [1:0] num;
    logic       has_index;
    logic       done;
    status_e    status;
  } job_ctrl_t;

endpackage

### rtl/tla_front.sv
// front end: mode register, list state and job building per accepted item
`timescale 1ns / 1ps

module tla_front import tla_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [MODE_W-1:0]             cfg_data_i,
  input  logic [OUT_INDEX_W-1:0]        vertex_index_i,
  input  logic                          list_last_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          q_full_i,
  output logic                          push_o,
  output job_ctrl_t                     push_ctrl_o,
  output logic [2:0][INDEX_WIDTH-1:0]   push_idx_o
);

  logic [MODE_W-1:0]      mode_q;
  logic [INDEX_WIDTH-1:0] older_q, newer_q, center_q;
  logic [1:0]             seen_q, phase_q;
  logic                   parity_q;

  logic [INDEX_WIDTH-1:0] cur;
  logic                   accept;
  job_ctrl_t              ctrl;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cur        = vertex_index_i[INDEX_WIDTH-1:0];
    ctrl       = '0;
    ctrl.status = STATUS_OK;
    push_idx_o = '0;
    case (mode_q)
      MODE_TRIANGLES: begin
        ctrl.num       = 2'd1;
        ctrl.has_index = 1'b1;
        push_idx_o[0]  = cur;
        // list length must reach a multiple of three on the marked item
        if (phase_q != 2'(TRI_SIDES - 1)) ctrl.status = STATUS_ODD_COUNT;
      end
      MODE_STRIP: begin
        if (seen_q == 2'd2) begin
          ctrl.num       = 2'd3;
          ctrl.has_index = 1'b1;
          push_idx_o[0]  = parity_q ? newer_q : older_q;
          push_idx_o[1]  = parity_q ? older_q : newer_q;
          push_idx_o[2]  = cur;
        end
      end
      MODE_FAN: begin
        if (seen_q == 2'd2) begin
          ctrl.num       = 2'd3;
          ctrl.has_index = 1'b1;
          push_idx_o[0]  = center_q;
          push_idx_o[1]  = newer_q;
          push_idx_o[2]  = cur;
        end
      end
      default: ctrl.status = STATUS_BAD_MODE;
    endcase
    // end of list with nothing emitted still gets one closing result
    if (list_last_i && ctrl.num == 2'd0) begin
      ctrl.num       = 2'd1;
      ctrl.has_index = 1'b0;
    end
    if (!list_last_i) ctrl.status = STATUS_OK;
    ctrl.done   = list_last_i;
    push_ctrl_o = ctrl;
    push_o      = accept && (ctrl.num != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      newer_q  <= '0;
      center_q <= '0;
      seen_q   <= '0;
      phase_q  <= '0;
      parity_q <= 1'b0;
    end else if (accept) begin
      if (list_last_i) begin
        older_q  <= '0;
        newer_q  <= '0;
        center_q <= '0;
        seen_q   <= '0;
        phase_q  <= '0;
        parity_q <= 1'b0;
      end else begin
        if (seen_q == 2'd0) center_q <= cur;
        if (seen_q == 2'd2) parity_q <= !parity_q;
        older_q <= newer_q;
        newer_q <= cur;
        phase_q <= (phase_q == 2'(TRI_SIDES - 1)) ? 2'd0 : phase_q + 2'd1;
        if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
      end
    end
  end

endmodule

### rtl/tla_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

`include "triangle_list_assembly_assert.svh"

module tla_queue import tla_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  job_ctrl_t                   push_ctrl_i,
  input  logic [2:0][INDEX_WIDTH-1:0] push_idx_i,
  output logic                        full_o,
  input  logic                        pop_i,
  output logic                        valid_o,
  output job_ctrl_t                   head_ctrl_o,
  output logic [2:0][INDEX_WIDTH-1:0] head_idx_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_ctrl_t                   ctrl_q [QUEUE_DEPTH];
  logic [2:0][INDEX_WIDTH-1:0] idx_q  [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            count_q;

  assign full_o      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o     = (count_q != '0);
  assign head_ctrl_o = ctrl_q[rd_ptr_q];
  assign head_idx_o  = idx_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctrl_q[wr_ptr_q] <= push_ctrl_i;
      idx_q[wr_ptr_q]  <= push_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `TLA_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "job pushed into full queue")
  `TLA_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> valid_o, "job popped from empty queue")

endmodule

### rtl/tla_back.sv
// back end: plays out one job's results, one per cycle while out_ready_i is high
`timescale 1ns / 1ps

`include "triangle_list_assembly_assert.svh"

module tla_back import tla_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  job_ctrl_t                   q_ctrl_i,
  input  logic [2:0][INDEX_WIDTH-1:0] q_idx_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [OUT_INDEX_W-1:0]      out_index_o,
  output logic                        index_valid_o,
  output logic                        run_last_o,
  output logic                        list_done_o,
  output logic [1:0]                  status_o
);

  logic                        busy_q;
  logic [1:0]                  step_q;
  job_ctrl_t                   ctrl_q;
  logic [2:0][INDEX_WIDTH-1:0] idx_q;

  logic last_step, load;

  assign last_step = (step_q == ctrl_q.num - 2'd1);
  // take the next job when idle or when the final result of this one leaves
  assign load      = !busy_q || (out_ready_i && last_step);
  assign pop_o     = load && q_valid_i;

  assign out_valid_o   = busy_q;
  assign out_index_o   = ctrl_q.has_index ? OUT_INDEX_W'(idx_q[step_q]) : '0;
  assign index_valid_o = ctrl_q.has_index;
  assign run_last_o    = last_step;
  assign list_done_o   = last_step && ctrl_q.done;
  assign status_o      = last_step ? ctrl_q.status : STATUS_OK;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ctrl_q <= q_ctrl_i;
      idx_q  <= q_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (load) begin
      busy_q <= q_valid_i;
      step_q <= '0;
    end else if (out_ready_i) begin
      step_q <= step_q + 2'd1;
    end
  end

  `TLA_ASSERT(a_step_in_job, clk_i, rst_ni, busy_q |-> (step_q < ctrl_q.num),
              "result step beyond job size")
  `TLA_ASSERT(a_done_is_last, clk_i, rst_ni, (out_valid_o && list_done_o) |-> run_last_o,
              "list end not on last result of item")
  `TLA_ASSERT(a_status_on_done, clk_i, rst_ni,
              (out_valid_o && (status_o != STATUS_OK)) |-> list_done_o,
              "status reported before list end")
  `TLA_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !out_valid_o,
                     "output valid right after reset")

endmodule

### rtl/triangle_list_assembly.sv
// Triangle list assembly: turns a stream of vertex indices into triangle-list
// indices by the primitive mode register (4 triangles, 5 strip, 6 fan).
// Input channel: vertex_index_i and list_last_i under in_valid_i/in_ready_o.
// Output channel: out_valid_o/out_ready_i, one result item per cycle while ready;
// run_last_o closes the results of one input item, list_done_o and status_o
// close a list (status 1 bad triangle count, 2 unsupported mode).
// cfg_we_i writes cfg_data_i into the mode register; write only while idle.
// With the back end free, an accepted item is written into the job queue, then
// loaded into the back end's job register that offers its first result.
// While the receiver is ready, triangles mode takes one item per cycle; once two
// indices are seen, each strip or fan item carries three results, and the single
// output port, drained one result per cycle by the back end, sets their pace.
// A two-entry job queue plus the back end's job register let the front keep
// accepting while results wait; when the receiver stalls, the queue fills and
// in_ready_o drops. Reset empties the queue, clears the list state and sets
// the mode to triangles; no clearing pass is needed.
`timescale 1ns / 1ps

module triangle_list_assembly import tla_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MODE_W-1:0]      cfg_data_i,
  input  logic [OUT_INDEX_W-1:0] vertex_index_i,
  input  logic                   list_last_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic [OUT_INDEX_W-1:0] out_index_o,
  output logic                   index_valid_o,
  output logic                   run_last_o,
  output logic                   list_done_o,
  output logic [1:0]             status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i
);

  logic                        push, full, q_valid, pop;
  job_ctrl_t                   push_ctrl, head_ctrl;
  logic [2:0][INDEX_WIDTH-1:0] push_idx, head_idx;

  tla_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_index_i (vertex_index_i),
    .list_last_i    (list_last_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .q_full_i       (full),
    .push_o         (push),
    .push_ctrl_o    (push_ctrl),
    .push_idx_o     (push_idx)
  );

  tla_queue #(.INDEX_WIDTH(INDEX_WIDTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ctrl_i (push_ctrl),
    .push_idx_i  (push_idx),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_ctrl_o (head_ctrl),
    .head_idx_o  (head_idx)
  );

  tla_back #(.INDEX_WIDTH(INDEX_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ctrl_i      (head_ctrl),
    .q_idx_i       (head_idx),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_index_o   (out_index_o),
    .index_valid_o (index_valid_o),
    .run_last_o    (run_last_o),
    .list_done_o   (list_done_o),
    .status_o      (status_o)
  );

endmodule
